@@ rtl/core/dictionary_word_stream_decoder_assert.svh @@
// assertion macros used by the checker file
`ifndef DICTIONARY_WORD_STREAM_DECODER_ASSERT_SVH
`define DICTIONARY_WORD_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DWSD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwsd: same-cycle check failed");

// next-cycle implication, checked outside reset
`define DWSD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwsd: next-cycle check failed");

`endif

@@ rtl/core/dwsd_pkg.sv @@
package dwsd_pkg;

    // table geometry
    localparam int INDEX_BITS       = 12;
    localparam int MAX_WORD_SYMBOLS = 7;
    localparam int TABLE_DEPTH      = 1 << INDEX_BITS;
    localparam int SYM_BITS         = 8 * MAX_WORD_SYMBOLS;
    localparam int COUNT_BITS       = 4;
    localparam int ENTRY_BITS       = SYM_BITS + COUNT_BITS;

    // port widths fixed by the interface
    localparam int WORD_BYTES       = 8;
    localparam int WORD_BITS        = 8 * WORD_BYTES;
    localparam int TINDEX_BITS      = 12;
    localparam int TSYM_BITS        = 56;
    localparam int CFG_DATA_BITS    = 8;

    // bit buffer
    localparam int BUF_BITS         = 32;
    localparam int HELD_BITS        = 5;

    // limits on the configuration values
    localparam logic [3:0] K_MIN = 4'd4;
    localparam logic [3:0] K_MAX = 4'd14;
    localparam logic [2:0] O_MAX = 3'd4;
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_WORD_SYMBOLS + 1);

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_START = 2'd1,
        FUNC_DATA  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_K_BITS       = 2'd0,
        CFG_OVERLAP_BITS = 2'd1,
        CFG_MOST_COMMON  = 2'd2
    } cfg_reg_t;

    // decode settings seen by the bit unpacker
    typedef struct packed {
        logic [3:0] k_bits;
        logic [2:0] overlap_bits;
    } decode_cfg_t;

    // one table lookup handed to the word stage
    typedef struct packed {
        logic                  valid;
        logic [INDEX_BITS-1:0] idx;
        logic                  last;
    } lookup_req_t;

endpackage

@@ rtl/core/dwsd_ram.sv @@
module dwsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port, read returns old data on a collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/dwsd_unpack.sv @@
module dwsd_unpack (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          func,
    input  logic [dwsd_pkg::TINDEX_BITS-1:0]    table_index,
    input  logic [dwsd_pkg::TSYM_BITS-1:0]      table_symbols,
    input  logic [dwsd_pkg::COUNT_BITS-1:0]     table_count,
    input  logic [7:0]                          data_byte,
    input  dwsd_pkg::decode_cfg_t               cfg,
    input  logic                                issue_ready,
    output dwsd_pkg::lookup_req_t               req,
    output logic                                wr_en,
    output logic [dwsd_pkg::INDEX_BITS-1:0]     wr_addr,
    output logic [dwsd_pkg::ENTRY_BITS-1:0]     wr_data
);

    import dwsd_pkg::*;

    logic [BUF_BITS-1:0]   buf_reg, buf_next;
    logic [HELD_BITS-1:0]  held_reg, held_next;
    logic [1:0]            pend_cnt_reg, pend_cnt_next;
    logic [INDEX_BITS-1:0] pend_head_reg, pend_head_next;
    logic [INDEX_BITS-1:0] pend_tail_reg, pend_tail_next;

    logic [3:0]            k_eff;
    logic [2:0]            o_eff;
    logic [HELD_BITS-1:0]  k5;
    logic [HELD_BITS-1:0]  width;
    logic [BUF_BITS-1:0]   wmask;
    logic [BUF_BITS-1:0]   buf1;
    logic [HELD_BITS-1:0]  held1, held2, held3;
    logic                  hit0, hit1;
    logic [INDEX_BITS-1:0] idx0, idx1;
    logic [HELD_BITS-1:0]  held_data;
    logic [BUF_BITS-1:0]   buf_data;
    logic                  issue;
    logic                  accept_ok;
    logic                  accept;
    func_t                 fn;

    // clamp the settings to their working range
    always_comb
    begin
        if (cfg.k_bits < K_MIN)
        begin
            k_eff = K_MIN;
        end
        else if (cfg.k_bits > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = cfg.k_bits;
        end
        o_eff = (cfg.overlap_bits > O_MAX) ? O_MAX : cfg.overlap_bits;
    end

    assign k5    = HELD_BITS'(k_eff);
    assign width = k5 + HELD_BITS'(o_eff);
    assign wmask = (BUF_BITS'(1) << width) - BUF_BITS'(1);

    // append the byte and find up to two lookup windows
    always_comb
    begin
        buf1  = {buf_reg[BUF_BITS-9:0], data_byte};
        held1 = held_reg + HELD_BITS'(8);
        hit0  = held1 >= width;
        idx0  = INDEX_BITS'((buf1 >> (held1 - width)) & wmask);
        held2 = held1 - k5;
        hit1  = hit0 && (held2 >= width);
        idx1  = INDEX_BITS'((buf1 >> (held2 - width)) & wmask);
        held3 = held2 - k5;
        if (hit1)
        begin
            held_data = held3;
        end
        else if (hit0)
        begin
            held_data = held2;
        end
        else
        begin
            held_data = held1;
        end
        buf_data = buf1 & ((BUF_BITS'(1) << held_data) - BUF_BITS'(1));
    end

    // lookup issue and input interlock
    assign issue     = (pend_cnt_reg != 2'd0) && issue_ready;
    assign accept_ok = (pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && issue_ready);
    assign in_stall  = !accept_ok;
    assign accept    = in_valid && accept_ok;
    assign fn        = func_t'(func);

    assign req.valid = pend_cnt_reg != 2'd0;
    assign req.idx   = pend_head_reg;
    assign req.last  = pend_cnt_reg == 2'd1;

    // table write goes straight to the memory
    assign wr_en   = accept && (fn == FUNC_WRITE);
    assign wr_addr = INDEX_BITS'(table_index);
    assign wr_data = {table_count, SYM_BITS'(table_symbols)};

    // next state of buffer and pending lookups
    always_comb
    begin
        buf_next       = buf_reg;
        held_next      = held_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_head_next = pend_head_reg;
        pend_tail_next = pend_tail_reg;
        if (issue)
        begin
            pend_cnt_next  = pend_cnt_reg - 2'd1;
            pend_head_next = pend_tail_reg;
        end
        if (accept)
        begin
            case (fn)
                FUNC_START:
                begin
                    buf_next  = '0;
                    held_next = HELD_BITS'(o_eff);
                end
                FUNC_DATA:
                begin
                    buf_next       = buf_data;
                    held_next      = held_data;
                    pend_cnt_next  = hit1 ? 2'd2 : (hit0 ? 2'd1 : 2'd0);
                    pend_head_next = idx0;
                    pend_tail_next = idx1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg      <= '0;
            held_reg     <= '0;
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            buf_reg      <= buf_next;
            held_reg     <= held_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // pending indexes
    always_ff @(posedge clk)
    begin
        pend_head_reg <= pend_head_next;
        pend_tail_reg <= pend_tail_next;
    end

endmodule

@@ rtl/core/dwsd_out.sv @@
module dwsd_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dwsd_pkg::lookup_req_t             req,
    output logic                              issue_ready,
    output logic                              rd_en,
    output logic [dwsd_pkg::INDEX_BITS-1:0]   rd_addr,
    input  logic [dwsd_pkg::ENTRY_BITS-1:0]   rd_data,
    input  logic [7:0]                        most_common_symbol,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dwsd_pkg::WORD_BITS-1:0]    word_symbols,
    output logic [dwsd_pkg::COUNT_BITS-1:0]   word_count,
    output logic                              last_of_run
);

    import dwsd_pkg::*;

    logic                  rd_pend_reg;
    logic                  rd_last_reg;
    logic [1:0]            fifo_cnt_reg, fifo_cnt_next;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [WORD_BITS-1:0]  sym_q_reg  [2];
    logic [COUNT_BITS-1:0] cnt_q_reg  [2];
    logic                  last_q_reg [2];

    logic                  pop;
    logic                  push;
    logic [1:0]            occ;
    logic [COUNT_BITS-1:0] cnt_raw;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic [WORD_BITS-1:0]  sym_ext;
    logic [WORD_BITS-1:0]  fmt_sym;

    // credit check: in-flight reads plus queued words never exceed two
    assign pop         = out_valid && !out_stall;
    assign push        = rd_pend_reg;
    assign occ         = fifo_cnt_reg + {1'b0, rd_pend_reg};
    assign issue_ready = (occ - {1'b0, pop}) < 2'd2;
    assign rd_en       = req.valid && issue_ready;
    assign rd_addr     = req.idx;

    // build the word from the table entry
    always_comb
    begin
        cnt_raw = rd_data[ENTRY_BITS-1 -: COUNT_BITS];
        cnt_sat = (cnt_raw > FULL_COUNT) ? FULL_COUNT : cnt_raw;
        sym_ext = WORD_BITS'(rd_data[SYM_BITS-1:0])
                | (WORD_BITS'(most_common_symbol) << SYM_BITS);
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            fmt_sym[8*j +: 8] = (COUNT_BITS'(j) < cnt_sat) ? sym_ext[8*j +: 8] : 8'd0;
        end
    end

    assign fifo_cnt_next = fifo_cnt_reg + {1'b0, push} - {1'b0, pop};

    // read tracking and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg  <= 1'b0;
            fifo_cnt_reg <= 2'd0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg  <= rd_en;
            fifo_cnt_reg <= fifo_cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // payload of the read and of the output queue
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_last_reg <= req.last;
        end
        if (push)
        begin
            sym_q_reg[wr_ptr_reg]  <= fmt_sym;
            cnt_q_reg[wr_ptr_reg]  <= cnt_sat;
            last_q_reg[wr_ptr_reg] <= rd_last_reg;
        end
    end

    assign out_valid    = fifo_cnt_reg != 2'd0;
    assign word_symbols = sym_q_reg[rd_ptr_reg];
    assign word_count   = cnt_q_reg[rd_ptr_reg];
    assign last_of_run  = last_q_reg[rd_ptr_reg];

endmodule

@@ rtl/core/dictionary_word_stream_decoder.sv @@
// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       func, table_index, table_symbols,
//                                                table_count, data_byte
// out       output     out_valid / out_stall     word_symbols, word_count, last_of_run
// cfg       input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a data byte causing at most one lookup is taken every cycle unless lookups are
// held back; one causing two lookups (k_bits of four to seven) stalls the next byte
// until its second lookup issues, set by the single read port of the word table.
// table writes and block starts issue no lookups. reset clears the bit buffer and
// queues and loads default settings; the word table has no reset and no clearing
// pass. out_stall holds back lookups once two words are queued or in flight.
module dictionary_word_stream_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [dwsd_pkg::TINDEX_BITS-1:0]  table_index,
    input  logic [dwsd_pkg::TSYM_BITS-1:0]    table_symbols,
    input  logic [dwsd_pkg::COUNT_BITS-1:0]   table_count,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dwsd_pkg::WORD_BITS-1:0]    word_symbols,
    output logic [dwsd_pkg::COUNT_BITS-1:0]   word_count,
    output logic                              last_of_run,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [dwsd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    import dwsd_pkg::*;

    logic [3:0]            k_bits_reg;
    logic [2:0]            overlap_bits_reg;
    logic [7:0]            most_common_reg;

    decode_cfg_t           cfg;
    lookup_req_t           req;
    logic                  issue_ready;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_addr;
    logic [ENTRY_BITS-1:0] rd_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_bits_reg       <= 4'd8;
            overlap_bits_reg <= 3'd0;
            most_common_reg  <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_K_BITS:       k_bits_reg       <= cfg_data[3:0];
                CFG_OVERLAP_BITS: overlap_bits_reg <= cfg_data[2:0];
                CFG_MOST_COMMON:  most_common_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.k_bits       = k_bits_reg;
    assign cfg.overlap_bits = overlap_bits_reg;

    // bit unpacker and lookup issue
    dwsd_unpack u_unpack (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .table_index   (table_index),
        .table_symbols (table_symbols),
        .table_count   (table_count),
        .data_byte     (data_byte),
        .cfg           (cfg),
        .issue_ready   (issue_ready),
        .req           (req),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // word table
    dwsd_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // word build and output queue
    dwsd_out u_out (
        .clk                (clk),
        .rst_n              (rst_n),
        .req                (req),
        .issue_ready        (issue_ready),
        .rd_en              (rd_en),
        .rd_addr            (rd_addr),
        .rd_data            (rd_data),
        .most_common_symbol (most_common_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .word_symbols       (word_symbols),
        .word_count         (word_count),
        .last_of_run        (last_of_run)
    );

endmodule

@@ rtl/core/dwsd_checker.sv @@
`include "dictionary_word_stream_decoder_assert.svh"

module dwsd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [dwsd_pkg::WORD_BITS-1:0]    word_symbols,
    input logic [dwsd_pkg::COUNT_BITS-1:0]   word_count,
    input logic                              last_of_run
);

    import dwsd_pkg::*;

    // word length never beyond a full word
    `DWSD_ASSERT_IMPL(a_count_range, clk, rst_n, out_valid, word_count <= FULL_COUNT)

    // an empty word carries no symbols
    `DWSD_ASSERT_IMPL(a_empty_word, clk, rst_n, out_valid && (word_count == '0), word_symbols == '0)

    // nothing is queued right after reset
    `DWSD_ASSERT_IMPL(a_reset_empty, clk, rst_n, $rose(rst_n), !out_valid)

    // a stalled word stays put
    `DWSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(word_symbols) && $stable(word_count) && $stable(last_of_run))

endmodule

bind dictionary_word_stream_decoder dwsd_checker u_dwsd_checker (.*);
